// ===== src/sprite_quad_setup_macros.svh =====
// ----------------------------------------------------------------------------
// Sprite quad setup assertion macros
// Concurrent check wrappers; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_SETUP_MACROS_SVH
`define SPRITE_QUAD_SETUP_MACROS_SVH
`ifndef SYNTHESIS
`define SQS_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`define SQS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define SQS_ASSERT(lbl, ante, cons)
`define SQS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite quad setup package
// Shared constants, types and the sine table builder.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int TAB_N           = 1 << SINE_TABLE_BITS;
  localparam int TAB_DEPTH       = TAB_N + 1;
  localparam int TAB_AW          = SINE_TABLE_BITS + 1;
  localparam int TAB_SH          = 14 - SINE_TABLE_BITS;
  localparam int DIV_STEPS_W     = 6;
  localparam int CFG_IDX_W       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_EXTENT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_U0         = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_V0         = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_DU         = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_DV         = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 4'd7;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  typedef struct packed {
    logic [31:0] half_extent;
    logic [15:0] tex_u0;
    logic [15:0] tex_v0;
    logic [15:0] tex_du;
    logic [15:0] tex_dv;
    logic [7:0]  grid_columns;
    logic [7:0]  grid_rows;
    logic [15:0] frame_interval;
  } cfg_t;

  typedef struct packed {
    logic signed [32:0] oxa;
    logic signed [32:0] oya;
    logic signed [16:0] sin_v;
    logic signed [16:0] cos_v;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [16:0]        u1;
    logic [16:0]        u2;
    logic [16:0]        v1;
    logic [16:0]        v2;
  } quad_t;

  typedef struct packed {
    logic                   start;
    logic [31:0]            dividend;
    logic [15:0]            divisor;
    logic [DIV_STEPS_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
    logic [15:0] rem;
  } div_rsp_t;

  typedef logic [15:0] sine_tab_t [TAB_DEPTH];

  function automatic longint unsigned udiv(input longint unsigned a,
                                           input longint unsigned b);
    longint unsigned q;
    longint unsigned rm;
    q  = '0;
    rm = '0;
    for (int i = 63; i >= 0; i--) begin
      rm = {rm[62:0], a[i]};
      if (rm >= b) begin
        rm   = rm - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t         t;
    longint unsigned   x;
    longint unsigned   term;
    longint unsigned   r;
    longint            sum;
    for (int k = 0; k <= TAB_N; k++) begin
      x    = (64'd1686629713 * longint'(k)) >> SINE_TABLE_BITS;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = udiv(term, longint'((2 * n) * (2 * n + 1)));
        if (n[0]) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (longint'(sum) + 64'd16384) >> 15;
      if (r > 64'd32768) r = 64'd32768;
      t[k] = r[15:0];
    end
    return t;
  endfunction

endpackage

// ===== src/spq_ifs.sv =====
// ----------------------------------------------------------------------------
// Sprite quad setup channel interfaces
// Request, corner and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface spq_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        frame_time;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic [15:0]        angle;
  logic signed [15:0] scale_h;
  logic signed [15:0] scale_v;
  modport source(output valid, frame_time, pos_x, pos_y, angle, scale_h, scale_v,
                 input ready);
  modport sink(input valid, frame_time, pos_x, pos_y, angle, scale_h, scale_v,
               output ready);
endinterface

interface spq_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         corner;
  logic signed [23:0] vert_x;
  logic signed [23:0] vert_y;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic               last;
  modport source(output valid, corner, vert_x, vert_y, tex_u, tex_v, last,
                 input ready);
  modport sink(input valid, corner, vert_x, vert_y, tex_u, tex_v, last,
               output ready);
endinterface

interface spq_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/spq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1025
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata0 <= mem_r[raddr0];
    rdata1 <= mem_r[raddr1];
  end

endmodule

// ===== src/spq_div.sv =====
// ----------------------------------------------------------------------------
// Sprite quad setup divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module spq_div import spq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [DIV_STEPS_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]            dd_r, dd_nxt;
  logic [31:0]            quo_r, quo_nxt;
  logic [15:0]            rem_r, rem_nxt;
  logic [15:0]            dsr_r, dsr_nxt;
  logic [16:0]            trial;
  logic                   fits;

  assign trial = {rem_r, dd_r[31]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dd_nxt   = dd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      dd_nxt   = req.dividend;
      dsr_nxt  = req.divisor;
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dd_nxt  = {dd_r[30:0], 1'b0};
      quo_nxt = {quo_r[30:0], fits};
      rem_nxt = fits ? 16'(trial - {1'b0, dsr_r}) : trial[15:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_STEPS_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dd_r  <= dd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== src/spq_front.sv =====
// ----------------------------------------------------------------------------
// Sprite quad setup front end
// Accept requests, derive atlas cell, trig and scaled extents.
// ----------------------------------------------------------------------------
module spq_front import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_ch,
  input  cfg_t       cfg,
  input  logic       fifo_full,
  output logic       push,
  output quad_t      push_data
);

  typedef enum logic [5:0] {
    ST_FILL = 6'b000001,
    ST_IDLE = 6'b000010,
    ST_DIV1 = 6'b000100,
    ST_DIV2 = 6'b001000,
    ST_DIV3 = 6'b010000,
    ST_PUSH = 6'b100000
  } fstate_t;

  localparam sine_tab_t SineTab = build_sine();

  fstate_t            state_r, state_nxt;
  logic [TAB_AW-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic               hold_v_r, hold_v_nxt;
  logic [31:0]        h_ftime_r;
  logic signed [23:0] h_px_r, h_py_r;
  logic [15:0]        h_ang_r;
  logic signed [15:0] h_sh_r, h_sv_r;
  logic signed [23:0] w_px_r, w_py_r;
  logic [15:0]        w_ang_r;
  logic signed [15:0] w_sh_r, w_sv_r;
  logic [7:0]         row_r, col_r;
  logic               accept, start;
  logic [7:0]         cols, rows;
  logic [15:0]        intv, ncells;
  div_req_t           dreq;
  div_rsp_t           drsp;
  logic [15:0]        sin_e, cos_e;
  logic [15:0]        cos_ang;
  logic [24:0]        u1w, u2w, v1w, v2w;

  function automatic logic [TAB_AW-1:0] tab_addr(input logic [15:0] a);
    logic [14:0] i;
    i = ({1'b0, a[13:0]} + 15'(1 << (TAB_SH - 1))) >> TAB_SH;
    if (i > 15'(TAB_N)) i = 15'(TAB_N);
    if (a[14]) i = 15'(TAB_N) - i;
    return i[TAB_AW-1:0];
  endfunction

  function automatic logic [16:0] tsat(input logic [24:0] t);
    return (t > 25'd131071) ? 17'd131071 : t[16:0];
  endfunction

  function automatic logic signed [16:0] trig(input logic [15:0] e, input logic neg);
    return neg ? -$signed({1'b0, e}) : $signed({1'b0, e});
  endfunction

  assign cols    = (cfg.grid_columns == 8'd0) ? 8'd1 : cfg.grid_columns;
  assign rows    = (cfg.grid_rows == 8'd0) ? 8'd1 : cfg.grid_rows;
  assign intv    = (cfg.frame_interval == 16'd0) ? 16'd1 : cfg.frame_interval;
  assign ncells  = 16'(cols) * 16'(rows);
  assign cos_ang = w_ang_r + 16'h4000;

  assign in_ch.ready = !hold_v_r && (state_r != ST_FILL);
  assign accept      = in_ch.valid && in_ch.ready;
  assign start       = (state_r == ST_IDLE) && hold_v_r;

  spq_ram #(.WIDTH(16), .DEPTH(TAB_DEPTH)) u_sine_ram (
    .clk    (clk),
    .we     (state_r == ST_FILL),
    .waddr  (fill_cnt_r),
    .wdata  (SineTab[fill_cnt_r]),
    .raddr0 (tab_addr(w_ang_r)),
    .raddr1 (tab_addr(cos_ang)),
    .rdata0 (sin_e),
    .rdata1 (cos_e)
  );

  spq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = h_ftime_r;
    dreq.divisor  = intv;
    dreq.steps    = DIV_STEPS_W'(32);
    case (state_r)
      ST_IDLE: dreq.start = hold_v_r;
      ST_DIV1: begin
        dreq.start    = drsp.done;
        dreq.dividend = drsp.quo;
        dreq.divisor  = ncells;
      end
      ST_DIV2: begin
        dreq.start    = drsp.done;
        dreq.dividend = {drsp.rem, 16'd0};
        dreq.divisor  = {8'd0, cols};
        dreq.steps    = DIV_STEPS_W'(16);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    fill_cnt_nxt = fill_cnt_r;
    case (state_r)
      ST_FILL: begin
        fill_cnt_nxt = fill_cnt_r + 1'b1;
        if (fill_cnt_r == TAB_AW'(TAB_N)) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (hold_v_r) state_nxt = ST_DIV1;
      ST_DIV1: if (drsp.done) state_nxt = ST_DIV2;
      ST_DIV2: if (drsp.done) state_nxt = ST_DIV3;
      ST_DIV3: if (drsp.done) state_nxt = ST_PUSH;
      ST_PUSH: if (!fifo_full) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    hold_v_nxt = hold_v_r;
    if (start) hold_v_nxt = 1'b0;
    if (accept) hold_v_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      fill_cnt_r <= '0;
      hold_v_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_cnt_r <= fill_cnt_nxt;
      hold_v_r   <= hold_v_nxt;
    end
    if (accept) begin
      h_ftime_r <= in_ch.frame_time;
      h_px_r    <= in_ch.pos_x;
      h_py_r    <= in_ch.pos_y;
      h_ang_r   <= in_ch.angle;
      h_sh_r    <= in_ch.scale_h;
      h_sv_r    <= (in_ch.scale_v == 16'sd0) ? in_ch.scale_h : in_ch.scale_v;
    end
    if (start) begin
      w_px_r  <= h_px_r;
      w_py_r  <= h_py_r;
      w_ang_r <= h_ang_r;
      w_sh_r  <= h_sh_r;
      w_sv_r  <= h_sv_r;
    end
    if ((state_r == ST_DIV3) && drsp.done) begin
      row_r <= drsp.quo[7:0];
      col_r <= drsp.rem[7:0];
    end
  end

  assign u1w = 25'(cfg.tex_u0) + 25'(cfg.tex_du * col_r);
  assign v1w = 25'(cfg.tex_v0) + 25'(cfg.tex_dv * row_r);
  assign u2w = u1w + 25'(cfg.tex_du);
  assign v2w = v1w + 25'(cfg.tex_dv);

  assign push = (state_r == ST_PUSH) && !fifo_full;

  always_comb begin
    push_data.oxa   = $signed({1'b0, cfg.half_extent[15:0]}) * w_sh_r;
    push_data.oya   = $signed({1'b0, cfg.half_extent[31:16]}) * w_sv_r;
    push_data.sin_v = trig(sin_e, w_ang_r[15]);
    push_data.cos_v = trig(cos_e, cos_ang[15]);
    push_data.pos_x = w_px_r;
    push_data.pos_y = w_py_r;
    push_data.u1    = tsat(u1w);
    push_data.u2    = tsat(u2w);
    push_data.v1    = tsat(v1w);
    push_data.v2    = tsat(v2w);
  end

endmodule

// ===== src/spq_fifo.sv =====
// ----------------------------------------------------------------------------
// Sprite quad setup queue
// Two-entry queue between front and back ends.
// ----------------------------------------------------------------------------
module spq_fifo import spq_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  quad_t wdata,
  output logic  full,
  input  logic  pop,
  output logic  head_v,
  output quad_t head
);

  quad_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full   = cnt_r == 2'd2;
  assign head_v = cnt_r != 2'd0;
  assign head   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wp_r] <= wdata;
  end

endmodule

// ===== src/spq_back.sv =====
// ----------------------------------------------------------------------------
// Sprite quad setup back end
// Rotate, round, place four corners, one beat per cycle while out_ch is ready.
// ----------------------------------------------------------------------------
`include "sprite_quad_setup_macros.svh"

module spq_back import spq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    head_v,
  input  quad_t   head,
  output logic    pop,
  spq_out_if.source out_ch
);

  logic               en, p_take;
  logic               p_v_r;
  logic [1:0]         k_r;
  logic signed [49:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [23:0] p_px_r, p_py_r;
  logic [16:0]        p_u1_r, p_u2_r, p_v1_r, p_v2_r;
  logic               s_v_r;
  logic [1:0]         s_k_r;
  logic signed [50:0] sx_r, sy_r;
  logic signed [23:0] s_px_r, s_py_r;
  logic [16:0]        s_u_r, s_v_tex_r;
  logic               o_v_r;
  logic [1:0]         o_k_r;
  logic signed [23:0] o_x_r, o_y_r;
  logic [16:0]        o_u_r, o_v_tex_r;
  logic               oxneg, oyneg;
  logic signed [50:0] a1, a2, a3, a4;

  function automatic logic signed [23:0] place(input logic signed [50:0] v,
                                               input logic signed [23:0] pos);
    logic signed [50:0] b;
    logic signed [27:0] r;
    b = v + 51'sd4194304;
    r = 28'(b >>> 23);
    r = r + {{4{pos[23]}}, pos};
    if (r > 28'sd8388607) r = 28'sd8388607;
    if (r < -28'sd8388608) r = -28'sd8388608;
    return r[23:0];
  endfunction

  assign en     = !o_v_r || out_ch.ready;
  assign p_take = !p_v_r || (en && (k_r == CORNER_BL));
  assign pop    = head_v && p_take;

  assign oxneg = (k_r == CORNER_TL) || (k_r == CORNER_BL);
  assign oyneg = (k_r == CORNER_BR) || (k_r == CORNER_BL);
  assign a1 = oxneg ? -51'(p1_r) : 51'(p1_r);
  assign a2 = oyneg ? -51'(p2_r) : 51'(p2_r);
  assign a3 = oxneg ? -51'(p3_r) : 51'(p3_r);
  assign a4 = oyneg ? -51'(p4_r) : 51'(p4_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      k_r   <= CORNER_TL;
      s_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (p_take) begin
        p_v_r <= head_v;
        k_r   <= CORNER_TL;
      end else if (en) begin
        k_r <= k_r + 1'b1;
      end
      if (en) begin
        s_v_r <= p_v_r;
        o_v_r <= s_v_r;
      end
    end
    if (pop) begin
      p1_r   <= head.oxa * head.cos_v;
      p2_r   <= head.oya * head.sin_v;
      p3_r   <= head.oxa * head.sin_v;
      p4_r   <= head.oya * head.cos_v;
      p_px_r <= head.pos_x;
      p_py_r <= head.pos_y;
      p_u1_r <= head.u1;
      p_u2_r <= head.u2;
      p_v1_r <= head.v1;
      p_v2_r <= head.v2;
    end
    if (en) begin
      s_k_r     <= k_r;
      sx_r      <= a1 - a2;
      sy_r      <= a3 + a4;
      s_px_r    <= p_px_r;
      s_py_r    <= p_py_r;
      s_u_r     <= oxneg ? p_u1_r : p_u2_r;
      s_v_tex_r <= oyneg ? p_v2_r : p_v1_r;
      o_k_r     <= s_k_r;
      o_x_r     <= place(sx_r, s_px_r);
      o_y_r     <= place(sy_r, s_py_r);
      o_u_r     <= s_u_r;
      o_v_tex_r <= s_v_tex_r;
    end
  end

  assign out_ch.valid  = o_v_r;
  assign out_ch.corner = o_k_r;
  assign out_ch.vert_x = o_x_r;
  assign out_ch.vert_y = o_y_r;
  assign out_ch.tex_u  = o_u_r;
  assign out_ch.tex_v  = o_v_tex_r;
  assign out_ch.last   = o_k_r == CORNER_BL;

  `SQS_ASSERT(a_no_reload_mid_quad, pop && p_v_r, k_r == CORNER_BL && en)
  `SQS_ASSERT_NEXT(a_corner_advance, p_v_r && en && k_r != CORNER_BL, k_r == $past(k_r) + 2'd1)
  `SQS_ASSERT_NEXT(a_hold_on_stall, p_v_r && !en, k_r == $past(k_r) && p_v_r)

endmodule

// ===== src/sprite_quad_setup.sv =====
// Flow: a request beat waits in a hold register (one more can be accepted
//   meanwhile), then three divider runs, a push, multiply, sum and place.
// Throughput: the shared serial divider serves one request at a time; the
//   corners of a quad leave at one beat per cycle while out_ch.ready is high.
// Reset: registers take their reset values; the 1025-entry sine memory is
//   filled after reset, with in_ch.ready low meanwhile.
// ----------------------------------------------------------------------------
// Sprite quad setup
// Turns one sprite request into four rotated, textured quad corners.
// ----------------------------------------------------------------------------
module sprite_quad_setup import spq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  spq_in_if.sink      in_ch,
  spq_out_if.source   out_ch,
  spq_cfg_if.sink     cfg_ch
);

  cfg_t  cfg_r, cfg_nxt;
  logic  push, full, pop, head_v;
  quad_t push_data, head;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_HALF_EXTENT:    cfg_nxt.half_extent    = cfg_ch.data;
        CFG_TEX_U0:         cfg_nxt.tex_u0         = cfg_ch.data[15:0];
        CFG_TEX_V0:         cfg_nxt.tex_v0         = cfg_ch.data[15:0];
        CFG_TEX_DU:         cfg_nxt.tex_du         = cfg_ch.data[15:0];
        CFG_TEX_DV:         cfg_nxt.tex_dv         = cfg_ch.data[15:0];
        CFG_GRID_COLUMNS:   cfg_nxt.grid_columns   = cfg_ch.data[7:0];
        CFG_GRID_ROWS:      cfg_nxt.grid_rows      = cfg_ch.data[7:0];
        CFG_FRAME_INTERVAL: cfg_nxt.frame_interval = cfg_ch.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_extent    <= '0;
      cfg_r.tex_u0         <= '0;
      cfg_r.tex_v0         <= '0;
      cfg_r.tex_du         <= 16'hFFFF;
      cfg_r.tex_dv         <= 16'hFFFF;
      cfg_r.grid_columns   <= 8'd1;
      cfg_r.grid_rows      <= 8'd1;
      cfg_r.frame_interval <= 16'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  spq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg       (cfg_r),
    .fifo_full (full),
    .push      (push),
    .push_data (push_data)
  );

  spq_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata  (push_data),
    .full   (full),
    .pop    (pop),
    .head_v (head_v),
    .head   (head)
  );

  spq_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head_v (head_v),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite quad setup testbench
// Sends sprite requests through the request channel under several register
// settings and checks every corner beat against a local corner predictor
// (sine lookup, rotation, rounding, saturation and atlas cell selection).
// ----------------------------------------------------------------------------
module tb;
  import spq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 4'd9;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 4'd15;
  localparam int PHASE_SETTLE = 120;
  localparam int LONG_HOLD    = 400;

  typedef struct {
    logic [31:0]        ftime;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [15:0]        ang;
    logic signed [15:0] sh;
    logic signed [15:0] sv;
  } sprite_req_t;

  typedef struct {
    logic [1:0]         corner;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic [16:0]        u;
    logic [16:0]        v;
    logic               last;
  } corner_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spq_in_if  in_ch();
  spq_out_if out_ch();
  spq_cfg_if cfg_ch();

  sprite_quad_setup DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [15:0] sine_lut [TAB_DEPTH];

  logic [31:0] m_half_extent  = 32'd0;
  logic [15:0] m_tex_u0       = 16'd0;
  logic [15:0] m_tex_v0       = 16'd0;
  logic [15:0] m_tex_du       = 16'hFFFF;
  logic [15:0] m_tex_dv       = 16'hFFFF;
  logic [7:0]  m_grid_columns = 8'd1;
  logic [7:0]  m_grid_rows    = 8'd1;
  logic [15:0] m_frame_intv   = 16'd1;

  sprite_req_t request_q[$];
  corner_t     corner_q[$];

  int  errors = 0;
  int  requests_sent = 0;
  int  corners_seen = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  int  hold_cnt = 0;
  bit  idle_en = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_taken = 1'b0;

  function automatic void fill_sine_lut();
    longint unsigned x, term, r;
    longint sum;
    for (int k = 0; k <= TAB_N; k++) begin
      x    = (64'd1686629713 * longint'(k)) >> SINE_TABLE_BITS;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 7; n++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / longint'((2 * n) * (2 * n + 1));
        if (n & 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (longint'(sum) + 64'd16384) >> 15;
      if (r > 64'd32768) r = 64'd32768;
      sine_lut[k] = r[15:0];
    end
  endfunction

  function automatic longint trig_lookup(logic [15:0] a);
    int unsigned i;
    longint e;
    i = (int'(a[13:0]) + (1 << (TAB_SH - 1))) >> TAB_SH;
    if (i > TAB_N) i = TAB_N;
    e = a[14] ? longint'(sine_lut[TAB_N - i]) : longint'(sine_lut[i]);
    return a[15] ? -e : e;
  endfunction

  function automatic logic [23:0] round_place(longint v, longint pos);
    longint r;
    r = ((v + (64'sd1 <<< 22)) >>> 23) + pos;
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[23:0];
  endfunction

  function automatic logic [16:0] tex_clip(longint unsigned t);
    return (t > 64'd131071) ? 17'h1FFFF : t[16:0];
  endfunction

  function automatic void predict_quad(sprite_req_t rq);
    longint sh, sv, hw, hh, s, c;
    longint ox[4], oy[4];
    longint unsigned cols, rows, intv, fr, u1, u2, v1, v2;
    longint unsigned us[4], vs[4];
    corner_t cr;
    sh = longint'(rq.sh);
    sv = longint'(rq.sv);
    if (sv == 0) sv = sh;
    hw = longint'(m_half_extent[15:0]);
    hh = longint'(m_half_extent[31:16]);
    ox[0] = -(hw * sh); ox[1] = hw * sh; ox[2] = hw * sh; ox[3] = -(hw * sh);
    oy[0] = hh * sv; oy[1] = hh * sv; oy[2] = -(hh * sv); oy[3] = -(hh * sv);
    s = trig_lookup(rq.ang);
    c = trig_lookup(rq.ang + 16'h4000);
    cols = (m_grid_columns == 0) ? 1 : longint'(m_grid_columns);
    rows = (m_grid_rows == 0) ? 1 : longint'(m_grid_rows);
    intv = (m_frame_intv == 0) ? 1 : longint'(m_frame_intv);
    fr = (longint'(rq.ftime) / intv) % (cols * rows);
    u1 = longint'(m_tex_u0) + longint'(m_tex_du) * (fr % cols);
    v1 = longint'(m_tex_v0) + longint'(m_tex_dv) * (fr / cols);
    u2 = u1 + longint'(m_tex_du);
    v2 = v1 + longint'(m_tex_dv);
    us[0] = u1; us[1] = u2; us[2] = u2; us[3] = u1;
    vs[0] = v1; vs[1] = v1; vs[2] = v2; vs[3] = v2;
    for (int k = 0; k < 4; k++) begin
      cr.corner = k[1:0];
      cr.vx     = round_place(ox[k] * c - oy[k] * s, longint'(rq.px));
      cr.vy     = round_place(ox[k] * s + oy[k] * c, longint'(rq.py));
      cr.u      = tex_clip(us[k]);
      cr.v      = tex_clip(vs[k]);
      cr.last   = (cr.corner == CORNER_BL);
      corner_q.push_back(cr);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    sprite_req_t rq;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        rq.ftime = in_ch.frame_time;
        rq.px    = in_ch.pos_x;
        rq.py    = in_ch.pos_y;
        rq.ang   = in_ch.angle;
        rq.sh    = in_ch.scale_h;
        rq.sv    = in_ch.scale_v;
        predict_quad(rq);
        requests_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (idle_en && request_q.size() > 0 && $urandom_range(0, 5) == 0) begin
          send_gap <= $urandom_range(1, 14) - 1;
          in_ch.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          rq = request_q.pop_front();
          in_ch.frame_time <= rq.ftime;
          in_ch.pos_x      <= rq.px;
          in_ch.pos_y      <= rq.py;
          in_ch.angle      <= rq.ang;
          in_ch.scale_h    <= rq.sh;
          in_ch.scale_v    <= rq.sv;
          in_ch.valid      <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // corner monitor
  always @(posedge clk) begin
    corner_t ex;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        corners_seen++;
        if (corner_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected corner beat: corner %0d x %0d y %0d", out_ch.corner,
                     out_ch.vert_x, out_ch.vert_y);
        end else begin
          ex = corner_q.pop_front();
          if (out_ch.corner !== ex.corner || out_ch.vert_x !== ex.vx ||
              out_ch.vert_y !== ex.vy || out_ch.tex_u !== ex.u ||
              out_ch.tex_v !== ex.v || out_ch.last !== ex.last) begin
            errors++;
            if (errors <= 10)
              $display(
                "corner mismatch: exp c%0d x%0d y%0d u%0d v%0d l%0d, got c%0d x%0d y%0d u%0d v%0d l%0d",
                ex.corner, ex.vx, ex.vy, ex.u, ex.v, ex.last,
                out_ch.corner, out_ch.vert_x, out_ch.vert_y, out_ch.tex_u,
                out_ch.tex_v, out_ch.last);
          end
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_cnt <= LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        recv_gap <= $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_HALF_EXTENT:    m_half_extent  = val;
      CFG_TEX_U0:         m_tex_u0       = val[15:0];
      CFG_TEX_V0:         m_tex_v0       = val[15:0];
      CFG_TEX_DU:         m_tex_du       = val[15:0];
      CFG_TEX_DV:         m_tex_dv       = val[15:0];
      CFG_GRID_COLUMNS:   m_grid_columns = val[7:0];
      CFG_GRID_ROWS:      m_grid_rows    = val[7:0];
      CFG_FRAME_INTERVAL: m_frame_intv   = val[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] he, logic [15:0] u0, logic [15:0] v0,
                           logic [15:0] du, logic [15:0] dv, logic [7:0] gc,
                           logic [7:0] gr, logic [15:0] fi);
    write_reg(CFG_HALF_EXTENT, he);
    write_reg(CFG_TEX_U0, {16'd0, u0});
    write_reg(CFG_TEX_V0, {16'd0, v0});
    write_reg(CFG_TEX_DU, {16'd0, du});
    write_reg(CFG_TEX_DV, {16'd0, dv});
    write_reg(CFG_GRID_COLUMNS, {24'd0, gc});
    write_reg(CFG_GRID_ROWS, {24'd0, gr});
    write_reg(CFG_FRAME_INTERVAL, {16'd0, fi});
  endtask

  task automatic add_req(logic [31:0] ft, logic [23:0] px, logic [23:0] py,
                         logic [15:0] ang, logic [15:0] sh, logic [15:0] sv);
    sprite_req_t rq;
    rq.ftime = ft; rq.px = px; rq.py = py; rq.ang = ang; rq.sh = sh; rq.sv = sv;
    request_q.push_back(rq);
  endtask

  task automatic add_random(int n);
    logic [15:0] ang, sh, sv;
    logic [23:0] px, py;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: ang = 16'h0000;
        1: ang = {2'($urandom_range(0, 3)), 14'h0000};
        default: ang = 16'($urandom);
      endcase
      sh = ($urandom_range(0, 3) == 0) ? 16'h1000 : 16'($urandom);
      sv = ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        px = 24'($signed($urandom_range(0, 4095)) - 2048);
        py = 24'($signed($urandom_range(0, 4095)) - 2048);
      end else begin
        px = 24'($urandom);
        py = 24'($urandom);
      end
      add_req($urandom, px, py, ang, sh, sv);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (request_q.size() > 0 || in_ch.valid || corner_q.size() > 0)
      @(negedge clk);
    repeat (PHASE_SETTLE) @(posedge clk);
  endtask

  initial begin
    fill_sine_lut();
    in_ch.valid = 1'b0;
    in_ch.frame_time = '0; in_ch.pos_x = '0; in_ch.pos_y = '0;
    in_ch.angle = '0; in_ch.scale_h = '0; in_ch.scale_v = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: zero extents put every corner on the anchor
    @(negedge clk);
    add_req(32'd0, 24'h000000, 24'h000000, 16'h0000, 16'h1000, 16'h0000);
    add_req(32'hFFFFFFFF, 24'h7FFFFF, 24'h800000, 16'hFFFF, 16'h7FFF, 16'h8000);
    add_req(32'd7, 24'h800000, 24'h7FFFFF, 16'h4000, 16'h8000, 16'h7FFF);
    drain();

    write_all({16'd96, 16'd64}, 16'h1000, 16'h2000, 16'h0800, 16'h1000,
              8'd4, 8'd3, 16'd5);
    @(negedge clk);
    add_req(32'd0, 24'h000100, 24'h000200, 16'h0000, 16'h1000, 16'h0000);
    add_req(32'd5, 24'h000100, 24'h000200, 16'h4000, 16'h1000, 16'h0000);
    add_req(32'd10, 24'h000100, 24'h000200, 16'h8000, 16'h1000, 16'h0000);
    add_req(32'd15, 24'h000100, 24'h000200, 16'hC000, 16'h1000, 16'h0000);
    add_req(32'd59, 24'h000000, 24'h000000, 16'hFFFF, 16'h1000, 16'h2000);
    add_req(32'd60, 24'h000000, 24'h000000, 16'h2000, 16'h1000, 16'h2000);
    add_req(32'd33, 24'h000000, 24'h000000, 16'h0008, 16'h1000, 16'h1000);
    add_req(32'd34, 24'h000000, 24'h000000, 16'h0007, 16'h1000, 16'h1000);
    add_req(32'd44, 24'h000000, 24'h000000, 16'h3FF8, 16'h7FFF, 16'h0000);
    add_req(32'hFFFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h0000, 16'h7FFF, 16'h7FFF);
    add_req(32'd1, 24'h800000, 24'h800000, 16'h0000, 16'h7FFF, 16'h7FFF);
    add_req(32'd2, 24'h000000, 24'h000000, 16'h1234, 16'h8000, 16'h0000);
    add_req(32'd3, 24'h000000, 24'h000000, 16'h0000, 16'hF000, 16'h1000);
    add_req(32'd4, 24'h000000, 24'h000000, 16'h0000, 16'h1000, 16'hF000);
    add_req(32'd9, 24'hFFFFFF, 24'h000001, 16'h6000, 16'h0000, 16'h0000);
    drain();

    // atlas and extents at their largest
    write_all(32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              8'd255, 8'd255, 16'd1);
    @(negedge clk);
    add_req(32'd0, 24'h000000, 24'h000000, 16'h0000, 16'h7FFF, 16'h8000);
    add_req(32'd65024, 24'h7FFFFF, 24'h800000, 16'hA000, 16'h8000, 16'h0000);
    add_random(40);
    drain();

    // zero divisors act as one; unknown indexes are ignored
    write_reg(CFG_GRID_COLUMNS, 32'd0);
    write_reg(CFG_GRID_ROWS, 32'd0);
    write_reg(CFG_FRAME_INTERVAL, 32'd0);
    write_reg(CFG_UNUSED_A, 32'hDEADBEEF);
    write_reg(CFG_UNUSED_B, 32'h12345678);
    write_reg(CFG_HALF_EXTENT, {16'd300, 16'd200});
    @(negedge clk);
    add_random(40);
    drain();

    // long receiver hold while requests keep coming
    write_all($urandom, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)),
              16'($urandom_range(1, 300)));
    @(negedge clk);
    add_random(70);
    @(posedge clk);
    hold_req <= 1'b1;
    drain();

    write_all({16'($urandom_range(0, 2047)), 16'($urandom_range(0, 2047))},
              16'($urandom), 16'($urandom), 16'($urandom_range(0, 4095)),
              16'($urandom_range(0, 4095)), 8'($urandom), 8'($urandom), 16'hFFFF);
    @(negedge clk);
    add_random(70);
    drain();

    // final stretch without idling on either side
    write_all($urandom, 16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
              16'($urandom), 16'($urandom), 8'd255, 8'd1, 16'($urandom_range(1, 8)));
    @(negedge clk);
    idle_en = 1'b0;
    add_random(90);
    drain();

    if (corner_q.size() > 0) errors += corner_q.size();
    $display("%0d sprite requests over seven register settings, %0d corner beats checked",
             requests_sent, corners_seen);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout after %0d requests, %0d corner beats", requests_sent, corners_seen);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
